// File: rtl/core/dpct_pkg.sv
// shared widths and types for the disc pair collision time pipeline
`timescale 1ns / 1ps

package dpct_pkg;

  // position and velocity differences
  localparam int unsigned DIFW  = 33;
  // radius sum
  localparam int unsigned SIGW  = 32;
  // closing speed term -d.v
  localparam int unsigned PW    = 67;
  // squared relative speed and squared distance
  localparam int unsigned VVW   = 66;
  // radicand of the root
  localparam int unsigned RADW  = 134;
  // root result
  localparam int unsigned ROOTW = 67;
  // root partial remainder
  localparam int unsigned SREMW = 68;
  // output time width
  localparam int unsigned TW    = 48;
  // one root bit per stage
  localparam int unsigned SQN   = 67;
  // one quotient bit per stage
  localparam int unsigned DIVN  = 48;

  // outcome flags that travel down the pipe
  typedef struct packed {
    logic nev;
    logic zr;
  } flag_t;

endpackage

// File: rtl/core/disc_pair_collision_time_top.sv
// disc pair collision time predictor, fully pipelined
// Usage: the input channel takes one disc pair per transaction (valid_i / stall_o) and
// the output channel returns one time per transaction (valid_o / stall_i).
// While stall_o is low a pair can enter every cycle, one transaction per clock.
// From acceptance to the outputs a pair passes through seven arithmetic stages,
// 67 square root stages (one root bit each), two setup stages, 48 divider
// stages (one quotient bit each) and the output register.
// The root and the divider are what set the depth.
// hit_time_o is all ones with never_hits_o set for same particle, moving apart,
// no relative motion, negative discriminant or a saturated time; otherwise an
// overlapping pair gives zero with never_hits_o clear.
// Reset (rst_ni low, asynchronous) empties every stage; no result is pending.
// When the receiver stalls, the result holds in the output register and one more
// result is caught in a skid register; the pipe then freezes and stall_o rises
// until the skid register drains. Nothing is lost or repeated.
`timescale 1ns / 1ps

module disc_pair_collision_time_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic signed [31:0] a_pos_x_i,
  input  logic signed [31:0] a_pos_y_i,
  input  logic signed [31:0] a_vel_x_i,
  input  logic signed [31:0] a_vel_y_i,
  input  logic        [30:0] a_radius_i,
  input  logic signed [31:0] b_pos_x_i,
  input  logic signed [31:0] b_pos_y_i,
  input  logic signed [31:0] b_vel_x_i,
  input  logic signed [31:0] b_vel_y_i,
  input  logic        [30:0] b_radius_i,
  input  logic               same_particle_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic [47:0]        hit_time_o,
  output logic               never_hits_o
);

  localparam int unsigned NW = dpct_pkg::PW + FRAC_BITS;

  logic en;
  logic skid_v_q;

  assign en      = !skid_v_q;
  assign stall_o = skid_v_q;

  // stage 1: differences and radius sum
  logic v1_q;
  logic signed [dpct_pkg::DIFW-1:0] dx1_q, dy1_q, dvx1_q, dvy1_q;
  logic [dpct_pkg::SIGW-1:0] sig1_q;
  logic same1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx1_q   <= {b_pos_x_i[31], b_pos_x_i} - {a_pos_x_i[31], a_pos_x_i};
      dy1_q   <= {b_pos_y_i[31], b_pos_y_i} - {a_pos_y_i[31], a_pos_y_i};
      dvx1_q  <= {b_vel_x_i[31], b_vel_x_i} - {a_vel_x_i[31], a_vel_x_i};
      dvy1_q  <= {b_vel_y_i[31], b_vel_y_i} - {a_vel_y_i[31], a_vel_y_i};
      sig1_q  <= {1'b0, a_radius_i} + {1'b0, b_radius_i};
      same1_q <= same_particle_i;
    end
  end

  // stage 2: products
  logic v2_q;
  logic signed [65:0] pxv2_q, pyv2_q, vxx2_q, vyy2_q, pxx2_q, pyy2_q;
  logic [63:0] ss2_q;
  logic nev2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pxv2_q <= dx1_q * dvx1_q;
      pyv2_q <= dy1_q * dvy1_q;
      vxx2_q <= dvx1_q * dvx1_q;
      vyy2_q <= dvy1_q * dvy1_q;
      pxx2_q <= dx1_q * dx1_q;
      pyy2_q <= dy1_q * dy1_q;
      ss2_q  <= sig1_q * sig1_q;
      nev2_q <= same1_q;
    end
  end

  // stage 3: dot products, moving apart check
  logic signed [dpct_pkg::PW-1:0] dvdr3;
  logic v3_q;
  logic [dpct_pkg::PW-1:0] p3_q;
  logic [dpct_pkg::VVW-1:0] dvdv3_q, drdr3_q;
  logic [63:0] ss3_q;
  logic nev3_q;

  assign dvdr3 = {pxv2_q[65], pxv2_q} + {pyv2_q[65], pyv2_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p3_q    <= ~dvdr3 + 1'b1;
      dvdv3_q <= vxx2_q + vyy2_q;
      drdr3_q <= pxx2_q + pyy2_q;
      ss3_q   <= ss2_q;
      nev3_q  <= nev2_q | (!dvdr3[dpct_pkg::PW-1] && (|dvdr3));
    end
  end

  // stage 4: squared distance minus squared contact distance, no motion check
  logic v4_q;
  logic [dpct_pkg::PW-1:0] p4_q;
  logic [dpct_pkg::VVW-1:0] dvdv4_q, diff4_q;
  logic ge4_q;
  logic nev4_q;
  logic ge3;

  assign ge3 = drdr3_q >= {2'b00, ss3_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (en) v4_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p4_q    <= p3_q;
      dvdv4_q <= dvdv3_q;
      diff4_q <= ge3 ? (drdr3_q - {2'b00, ss3_q}) : ({2'b00, ss3_q} - drdr3_q);
      ge4_q   <= ge3;
      nev4_q  <= nev3_q | (dvdv3_q == '0);
    end
  end

  // stage 5: partial products of p*p and dvdv*diff
  logic v5_q;
  logic [67:0] ppll5_q;
  logic [66:0] pplh5_q;
  logic [65:0] pphh5_q;
  logic [65:0] tll5_q, tlh5_q, thl5_q, thh5_q;
  logic [dpct_pkg::PW-1:0] p5_q;
  logic [dpct_pkg::VVW-1:0] dvdv5_q;
  logic ge5_q, nev5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (en) v5_q <= v4_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ppll5_q <= p4_q[33:0] * p4_q[33:0];
      pplh5_q <= p4_q[33:0] * p4_q[66:34];
      pphh5_q <= p4_q[66:34] * p4_q[66:34];
      tll5_q  <= dvdv4_q[32:0] * diff4_q[32:0];
      tlh5_q  <= dvdv4_q[32:0] * diff4_q[65:33];
      thl5_q  <= dvdv4_q[65:33] * diff4_q[32:0];
      thh5_q  <= dvdv4_q[65:33] * diff4_q[65:33];
      p5_q    <= p4_q;
      dvdv5_q <= dvdv4_q;
      ge5_q   <= ge4_q;
      nev5_q  <= nev4_q;
    end
  end

  // stage 6: combine partial products
  logic v6_q;
  logic [dpct_pkg::RADW-1:0] pp6_q;
  logic [131:0] t6_q;
  logic [dpct_pkg::PW-1:0] p6_q;
  logic [dpct_pkg::VVW-1:0] dvdv6_q;
  logic ge6_q, nev6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else if (en) v6_q <= v5_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pp6_q   <= 134'(ppll5_q) + (134'(pplh5_q) << 35) + (134'(pphh5_q) << 68);
      t6_q    <= 132'(tll5_q) + ((132'(tlh5_q) + 132'(thl5_q)) << 33)
                 + (132'(thh5_q) << 66);
      p6_q    <= p5_q;
      dvdv6_q <= dvdv5_q;
      ge6_q   <= ge5_q;
      nev6_q  <= nev5_q;
    end
  end

  // stage 7: discriminant, loads the first root stage
  logic sq_v_q [0:dpct_pkg::SQN];
  logic [dpct_pkg::SREMW-1:0] sq_rem_q [0:dpct_pkg::SQN];
  logic [dpct_pkg::ROOTW-1:0] sq_root_q [0:dpct_pkg::SQN];
  logic [dpct_pkg::RADW-1:0] sq_rad_q [0:dpct_pkg::SQN];
  logic [dpct_pkg::PW-1:0] sq_p_q [0:dpct_pkg::SQN];
  logic [dpct_pkg::VVW-1:0] sq_dvdv_q [0:dpct_pkg::SQN];
  logic sq_nev_q [0:dpct_pkg::SQN];
  logic [dpct_pkg::RADW-1:0] t6_ext;

  assign t6_ext = {2'b00, t6_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sq_v_q[0] <= 1'b0;
    else if (en) sq_v_q[0] <= v6_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_rem_q[0]  <= '0;
      sq_root_q[0] <= '0;
      sq_rad_q[0]  <= ge6_q ? (pp6_q - t6_ext) : (pp6_q + t6_ext);
      sq_p_q[0]    <= p6_q;
      sq_dvdv_q[0] <= dvdv6_q;
      sq_nev_q[0]  <= nev6_q | (ge6_q && (pp6_q < t6_ext));
    end
  end

  // square root, one result bit per stage
  for (genvar k = 0; k < dpct_pkg::SQN; k++) begin : g_sqrt
    logic [dpct_pkg::SREMW+1:0] cur, trial;
    logic take;

    assign cur   = {sq_rem_q[k], sq_rad_q[k][dpct_pkg::RADW-1 -: 2]};
    assign trial = {1'b0, sq_root_q[k], 2'b01};
    assign take  = cur >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sq_v_q[k+1] <= 1'b0;
      else if (en) sq_v_q[k+1] <= sq_v_q[k];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_rem_q[k+1]  <= take ? dpct_pkg::SREMW'(cur - trial)
                               : cur[dpct_pkg::SREMW-1:0];
        sq_root_q[k+1] <= {sq_root_q[k][dpct_pkg::ROOTW-2:0], take};
        sq_rad_q[k+1]  <= sq_rad_q[k] << 2;
        sq_p_q[k+1]    <= sq_p_q[k];
        sq_dvdv_q[k+1] <= sq_dvdv_q[k];
        sq_nev_q[k+1]  <= sq_nev_q[k];
      end
    end
  end

  // stage a: contact now check and numerator
  logic va_q;
  logic [dpct_pkg::PW-1:0] numa_q;
  logic [dpct_pkg::VVW-1:0] dvdva_q;
  dpct_pkg::flag_t fla_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) va_q <= 1'b0;
    else if (en) va_q <= sq_v_q[dpct_pkg::SQN];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      numa_q  <= sq_p_q[dpct_pkg::SQN] - sq_root_q[dpct_pkg::SQN];
      dvdva_q <= sq_dvdv_q[dpct_pkg::SQN];
      fla_q.nev <= sq_nev_q[dpct_pkg::SQN];
      fla_q.zr  <= sq_root_q[dpct_pkg::SQN] >= sq_p_q[dpct_pkg::SQN];
    end
  end

  // stage b: saturation check, loads the first divider stage
  logic [NW-1:0] numb;
  logic [NW-1:0] dvdv_hi;
  logic satb;
  logic dv_v_q [0:dpct_pkg::DIVN];
  logic [dpct_pkg::VVW-1:0] dv_rem_q [0:dpct_pkg::DIVN];
  logic [dpct_pkg::TW-1:0] dv_lo_q [0:dpct_pkg::DIVN];
  logic [dpct_pkg::TW-1:0] dv_quo_q [0:dpct_pkg::DIVN];
  logic [dpct_pkg::VVW-1:0] dv_den_q [0:dpct_pkg::DIVN];
  dpct_pkg::flag_t dv_fl_q [0:dpct_pkg::DIVN];
  logic [dpct_pkg::VVW+dpct_pkg::TW-1:0] den_sh;

  assign numb   = {numa_q, FRAC_BITS'(0)};
  assign den_sh = {dvdva_q, dpct_pkg::TW'(0)};
  assign dvdv_hi = NW'(dvdva_q);
  // quotient reaches 2^48 when the numerator is at least den << 48
  assign satb   = ((dpct_pkg::VVW + dpct_pkg::TW + NW)'(numb)
                  >= (dpct_pkg::VVW + dpct_pkg::TW + NW)'(den_sh));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_v_q[0] <= 1'b0;
    else if (en) dv_v_q[0] <= va_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_rem_q[0]    <= dpct_pkg::VVW'(numb >> dpct_pkg::TW);
      dv_lo_q[0]     <= numb[dpct_pkg::TW-1:0];
      dv_quo_q[0]    <= '0;
      dv_den_q[0]    <= dvdv_hi[dpct_pkg::VVW-1:0];
      dv_fl_q[0].nev <= fla_q.nev | (satb & ~fla_q.zr);
      dv_fl_q[0].zr  <= fla_q.zr;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar j = 0; j < dpct_pkg::DIVN; j++) begin : g_div
    logic [dpct_pkg::VVW:0] cur;
    logic take;

    assign cur  = {dv_rem_q[j], dv_lo_q[j][dpct_pkg::TW-1]};
    assign take = cur >= {1'b0, dv_den_q[j]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_v_q[j+1] <= 1'b0;
      else if (en) dv_v_q[j+1] <= dv_v_q[j];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_rem_q[j+1] <= take ? dpct_pkg::VVW'(cur - {1'b0, dv_den_q[j]})
                              : cur[dpct_pkg::VVW-1:0];
        dv_lo_q[j+1]  <= dv_lo_q[j] << 1;
        dv_quo_q[j+1] <= {dv_quo_q[j][dpct_pkg::TW-2:0], take};
        dv_den_q[j+1] <= dv_den_q[j];
        dv_fl_q[j+1]  <= dv_fl_q[j];
      end
    end
  end

  // result selection
  logic [dpct_pkg::TW-1:0] res_time;
  logic res_nev, res_v;
  dpct_pkg::flag_t res_fl;

  assign res_v  = dv_v_q[dpct_pkg::DIVN];
  assign res_fl = dv_fl_q[dpct_pkg::DIVN];
  assign res_nev = res_fl.nev;
  assign res_time = res_fl.nev ? '1 : (res_fl.zr ? '0 : dv_quo_q[dpct_pkg::DIVN]);

  // output register with skid stage
  logic out_v_q;
  logic [dpct_pkg::TW-1:0] out_time_q, skid_time_q;
  logic out_nev_q, skid_nev_q;
  logic pop, inc;

  assign pop = out_v_q && !stall_i;
  assign inc = en && res_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (pop) skid_v_q <= 1'b0;
    end else if (inc) begin
      if (out_v_q && !pop) skid_v_q <= 1'b1;
      else out_v_q <= 1'b1;
    end else if (pop) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop) begin
        out_time_q <= skid_time_q;
        out_nev_q  <= skid_nev_q;
      end
    end else if (inc) begin
      if (out_v_q && !pop) begin
        skid_time_q <= res_time;
        skid_nev_q  <= res_nev;
      end else begin
        out_time_q <= res_time;
        out_nev_q  <= res_nev;
      end
    end
  end

  assign valid_o      = out_v_q;
  assign hit_time_o   = out_time_q;
  assign never_hits_o = out_nev_q;

endmodule

// File: sim/tb_disc_pair_collision_time_top.sv
// testbench for the disc pair collision time predictor: table-driven and random pairs
`timescale 1ns / 1ps

module tb_disc_pair_collision_time_top;

  localparam int unsigned FRAC = 16;
  localparam logic [47:0] NEVER_TIME = '1;
  localparam logic [31:0] ONE = 32'h0001_0000;

  // one disc pair as driven on the input ports
  typedef struct {
    logic signed [31:0] apx, apy, avx, avy;
    logic        [30:0] ar;
    logic signed [31:0] bpx, bpy, bvx, bvy;
    logic        [30:0] br;
    logic               same;
  } disc_pair_t;

  typedef struct {
    logic [47:0] t;
    logic        nev;
  } hit_t;

  // directed row: pair plus an optional typed-in answer
  typedef struct {
    disc_pair_t pair;
    logic       fixed;
    hit_t       ans;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_i = 1'b0;
  logic stall_o, valid_o, never_hits_o;
  logic [47:0] hit_time_o;
  disc_pair_t drv = '{default: '0};

  hit_t hit_q[$];
  int unsigned errors = 0;
  int unsigned hold_left = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;

  disc_pair_collision_time_top #(.FRAC_BITS(FRAC)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(valid_i), .stall_o(stall_o),
    .a_pos_x_i(drv.apx), .a_pos_y_i(drv.apy), .a_vel_x_i(drv.avx), .a_vel_y_i(drv.avy),
    .a_radius_i(drv.ar), .b_pos_x_i(drv.bpx), .b_pos_y_i(drv.bpy), .b_vel_x_i(drv.bvx),
    .b_vel_y_i(drv.bvy), .b_radius_i(drv.br), .same_particle_i(drv.same),
    .valid_o(valid_o), .stall_i(stall_i), .hit_time_o(hit_time_o),
    .never_hits_o(never_hits_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // exact time to contact from wide integer arithmetic
  function automatic hit_t contact_time(disc_pair_t c);
    logic signed [33:0] dx, dy, dvx, dvy;
    logic signed [127:0] dvdr;
    logic [191:0] p, dvdv, drdr, s2, pp, rad, root, rbit, q;
    logic [31:0] sig;
    hit_t never;
    never.t = NEVER_TIME;
    never.nev = 1'b1;
    if (c.same) return never;
    dx = c.bpx - c.apx;
    dy = c.bpy - c.apy;
    dvx = c.bvx - c.avx;
    dvy = c.bvy - c.avy;
    dvdr = dx * dvx + dy * dvy;
    if (dvdr > 0) return never;
    p = -dvdr;
    dvdv = dvx * dvx + dvy * dvy;
    if (dvdv == 0) return never;
    drdr = dx * dx + dy * dy;
    sig = c.ar + c.br;
    s2 = sig * sig;
    pp = p * p;
    if (drdr >= s2) begin
      if (pp < dvdv * (drdr - s2)) return never;
      rad = pp - dvdv * (drdr - s2);
    end else begin
      rad = pp + dvdv * (s2 - drdr);
    end
    // bitwise floor square root
    root = '0;
    rbit = 192'b1 << 190;
    for (int i = 0; i < 96; i++) begin
      if (rad >= root + rbit) begin
        rad = rad - (root + rbit);
        root = (root >> 1) + rbit;
      end else begin
        root = root >> 1;
      end
      rbit = rbit >> 2;
    end
    if (root >= p) return '{t: '0, nev: 1'b0};
    q = ((p - root) << FRAC) / dvdv;
    if (q >= (192'b1 << 48)) return never;
    return '{t: q[47:0], nev: 1'b0};
  endfunction

  function automatic logic signed [31:0] rnd_signed(int unsigned w);
    return $signed($urandom()) >>> (32 - w);
  endfunction

  // mostly closing pairs at a random scale, some pure noise
  function automatic disc_pair_t random_pair();
    disc_pair_t c;
    int unsigned w;
    logic signed [31:0] dx, dy;
    w = $urandom_range(4, 28);
    if ($urandom_range(0, 9) < 2) begin
      c = '{apx: $urandom(), apy: $urandom(), avx: $urandom(), avy: $urandom(),
            ar: 31'($urandom()), bpx: $urandom(), bpy: $urandom(), bvx: $urandom(),
            bvy: $urandom(), br: 31'($urandom()), same: 1'($urandom())};
    end else begin
      dx = rnd_signed(w);
      dy = rnd_signed(w);
      c.apx = rnd_signed(w);
      c.apy = rnd_signed(w);
      c.bpx = c.apx + dx;
      c.bpy = c.apy + dy;
      c.avx = rnd_signed(w);
      c.avy = rnd_signed(w);
      c.bvx = c.avx - (dx >>> $urandom_range(0, 6)) + rnd_signed($urandom_range(1, w));
      c.bvy = c.avy - (dy >>> $urandom_range(0, 6)) + rnd_signed($urandom_range(1, w));
      c.ar = 31'($urandom() >> (33 - w));
      c.br = 31'($urandom() >> (33 - w));
      c.same = ($urandom_range(0, 15) == 0);
    end
    return c;
  endfunction

  // offer one transaction, queue its answer once accepted
  task automatic send_pair(disc_pair_t c);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk_i);
      valid_i <= 1'b0;
    end
    @(negedge clk_i);
    drv <= c;
    valid_i <= 1'b1;
    do @(posedge clk_i); while (stall_o);
    hit_q.push_back(contact_time(c));
  endtask

  task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
    errors++;
    $display("%0t: %s mismatch: got %h expected %h", $realtime, what, got, want);
  endtask

  // receiver stall, with a long hold-off when requested
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      stall_i <= 1'b1;
    end else begin
      stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i) begin
      if (hit_q.size() == 0) begin
        report_mismatch("unexpected transaction", hit_time_o, '0);
      end else begin
        if (hit_time_o !== hit_q[0].t) report_mismatch("hit_time", hit_time_o, hit_q[0].t);
        if (never_hits_o !== hit_q[0].nev)
          report_mismatch("never_hits", never_hits_o, hit_q[0].nev);
        void'(hit_q.pop_front());
      end
    end
  end

  initial begin
    #4_000_000;
    $display("disc_pair_collision_time_top verification failed");
    $finish;
  end

  initial begin
    row_t rows[$];
    disc_pair_t z;
    disc_pair_t c;
    hit_t want;
    int unsigned n;
    z = '{default: '0};

    // no motion at all
    rows.push_back('{z, 1'b1, '{NEVER_TIME, 1'b1}});
    // same particle
    c = z; c.bpx = 10 * ONE; c.bvx = -ONE; c.same = 1'b1;
    rows.push_back('{c, 1'b1, '{NEVER_TIME, 1'b1}});
    // head-on at distance ten, unit speed, radii one: contact at eight
    c.same = 1'b0; c.ar = ONE[30:0]; c.br = ONE[30:0];
    rows.push_back('{c, 1'b1, '{48'h8_0000, 1'b0}});
    // moving apart
    c.bvx = ONE;
    rows.push_back('{c, 1'b1, '{NEVER_TIME, 1'b1}});
    // already overlapping and closing
    c = z; c.bpx = ONE; c.bvx = -ONE; c.ar = ONE[30:0]; c.br = ONE[30:0];
    rows.push_back('{c, 1'b1, '{48'h0, 1'b0}});
    // miss sideways: negative discriminant
    c = z; c.bpx = 10 * ONE; c.bpy = 5 * ONE; c.bvx = -ONE;
    c.ar = ONE[30:0]; c.br = ONE[30:0];
    rows.push_back('{c, 1'b1, '{NEVER_TIME, 1'b1}});
    // far apart, crawling: very large time, still in range
    c = z; c.bpx = 32'h7fff_ffff; c.bvx = -1;
    rows.push_back('{c, 1'b1, '{48'h7fff_ffff_0000, 1'b0}});
    // extremes of every field
    c = '{apx: 32'h8000_0000, apy: 32'h8000_0000, avx: 32'h7fff_ffff,
          avy: 32'h7fff_ffff, ar: '1, bpx: 32'h7fff_ffff, bpy: 32'h7fff_ffff,
          bvx: 32'h8000_0000, bvy: 32'h8000_0000, br: '1, same: 1'b0};
    rows.push_back('{c, 1'b0, '{'0, 1'b0}});
    c.ar = '0; c.br = '0;
    rows.push_back('{c, 1'b0, '{'0, 1'b0}});
    c = '{apx: 32'h7fff_ffff, apy: 32'h8000_0000, avx: 32'h8000_0000,
          avy: 32'h7fff_ffff, ar: 31'd1, bpx: 32'h8000_0000, bpy: 32'h7fff_ffff,
          bvx: 32'h7fff_ffff, bvy: 32'h8000_0000, br: '1, same: 1'b0};
    rows.push_back('{c, 1'b0, '{'0, 1'b0}});
    c = z; c.bpx = 3 * ONE; c.bpy = 4 * ONE; c.bvx = -3; c.bvy = -4; c.ar = ONE[30:0];
    rows.push_back('{c, 1'b0, '{'0, 1'b0}});
    c = z; c.bpx = -1; c.bvx = 1; c.ar = 31'd1;
    rows.push_back('{c, 1'b0, '{'0, 1'b0}});

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table, typed answers checked against the predictor too
    foreach (rows[i]) begin
      want = contact_time(rows[i].pair);
      if (rows[i].fixed && (want.t !== rows[i].ans.t || want.nev !== rows[i].ans.nev))
        report_mismatch("table row", rows[i].ans.t, want.t);
      send_pair(rows[i].pair);
    end

    // random phases with different idling and receiver stalling
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1) ? 74 : (ph == 3) ? 30 : 0;
      stall_pct = (ph == 2) ? 74 : (ph == 3) ? 30 : 0;
      n = 0;
      repeat (400) begin
        if (ph == 0 && n == 50) hold_left = 400;
        if (n == 200) begin
          @(negedge clk_i);
          valid_i <= 1'b0;
          wait (hit_q.size() == 0);
        end
        send_pair(random_pair());
        n++;
      end
    end
    @(negedge clk_i);
    valid_i <= 1'b0;

    wait (hit_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && hit_q.size() == 0) begin
      $display("disc_pair_collision_time_top verification clean");
    end else begin
      $display("disc_pair_collision_time_top verification failed");
    end
    $finish;
  end

endmodule
